// ===== design/nev_pkg.sv =====
// Package for the Neville polynomial interpolation unit.
// Holds the number formats, store geometry, codes and the clipping helper.
// Depends on nothing.
`default_nettype none

package nev_pkg;

   localparam int MAX_NODES = 16;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 5;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   localparam logic [DATA_W-1:0] Q_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] Q_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] Q_MIN_SYM = {1'b1, {(DATA_W-2){1'b0}}, 1'b1};

   localparam logic       OP_LOAD = 1'b0;
   localparam logic       OP_EVAL = 1'b1;
   localparam logic       REG_NODE_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(2);

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clipped;
   } clip_type;

   // Clips a 33-bit difference to the symmetric Q16.16 range.
   function automatic clip_type clip_sym(input logic signed [DATA_W:0] v);
      clip_type r;
      r.clipped = 1'b0;
      r.value   = v[DATA_W-1:0];
      if (v > $signed({2'b00, Q_MAX[DATA_W-2:0]})) begin
         r.value   = Q_MAX;
         r.clipped = 1'b1;
      end else if (v < $signed({1'b1, Q_MIN_SYM})) begin
         r.value   = Q_MIN_SYM;
         r.clipped = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/neville_polynomial_interpolation_unit.sv =====
// Top level of the Neville polynomial interpolation unit.
// Node stores, working column, sequencer, shared multiplier and divider.
// Depends on nev_pkg.
`default_nettype none

// A load item writes one node and busy stays low. An evaluation first compares
// every pair of the first n nodes (a read state and a compare state per pair),
// then runs n(n-1)/2 Neville steps, each with a bit-serial divide that gives one
// quotient bit a cycle over 64 bits. Equal abscissas end the evaluation early.
// The result is shown for one cycle with rsp_valid and the receiver cannot stall.
module neville_polynomial_interpolation_unit
   import nev_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic                req_operation,
   input  wire logic [IDX_W-1:0]    req_node_index,
   input  wire logic [DATA_W-1:0]   req_node_x,
   input  wire logic [DATA_W-1:0]   req_node_y,
   input  wire logic [DATA_W-1:0]   req_query_point,
   output      logic                rsp_valid,
   output      logic [DATA_W-1:0]   rsp_value,
   output      logic                rsp_divide_by_zero,
   output      logic                rsp_saturated,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output      logic [31:0]         prdata,
   output      logic                pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_DUP_RD, S_DUP_CMP, S_NV_RD, S_NV_DIFF, S_NV_MUL_L,
      S_NV_MUL_R, S_NV_NUM, S_NV_DIV, S_NV_WB
   } state_type;

   state_type state_ff;

   logic [COUNT_W-1:0] node_count_ff;

   logic [DATA_W-1:0] abscissa_mem [MAX_NODES];
   logic [DATA_W-1:0] ordinate_mem [MAX_NODES];
   logic [DATA_W-1:0] column_mem   [MAX_NODES];

   logic [DATA_W-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff, p_lo_ff, p_hi_ff;
   logic [IDX_W-1:0]  x_addr_lo_in, x_addr_hi_in;

   logic [IDX_W-1:0]  a_ff, b_ff, k_ff, m_ff, n_last_ff;
   logic [DATA_W-1:0] t_ff;
   logic              sat_ff;

   logic signed [DATA_W-1:0] dl_ff, dr_ff, pk_ff, pk1_ff;
   logic signed [DATA_W:0]   den_ff;
   logic signed [PROD_W-1:0] prod_l_ff, prod_r_ff;

   logic [PROD_W-1:0]    quo_ff;
   logic [DATA_W+1:0]    rem_ff;
   logic [DATA_W:0]      dmag_ff;
   logic                 qneg_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic                rsp_valid_ff, rsp_dz_ff, rsp_sat_ff;
   logic [DATA_W-1:0]   rsp_value_ff;

   // ---------------- configuration port ----------------
   logic cfg_write;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (cfg_write && paddr[2] == REG_NODE_COUNT) begin
         node_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_NODE_COUNT) begin
         prdata = {{(32-COUNT_W){1'b0}}, node_count_ff};
      end
   end

   // ---------------- memories ----------------
   logic load_en;
   assign load_en = start && !busy && req_operation == OP_LOAD;

   always_comb begin
      if (state_ff == S_DUP_RD || state_ff == S_DUP_CMP) begin
         x_addr_lo_in = a_ff;
         x_addr_hi_in = b_ff;
      end else begin
         x_addr_lo_in = k_ff;
         x_addr_hi_in = k_ff + m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         abscissa_mem[req_node_index] <= req_node_x;
         ordinate_mem[req_node_index] <= req_node_y;
      end
      x_lo_ff <= abscissa_mem[x_addr_lo_in];
      x_hi_ff <= abscissa_mem[x_addr_hi_in];
      y_lo_ff <= ordinate_mem[k_ff];
      y_hi_ff <= ordinate_mem[k_ff + 1'b1];
   end

   // Column entry k is only written in the write-back state, after all reads of the
   // step have completed, so reads and writes of one entry never overlap.
   logic [DATA_W-1:0] clip_result;
   always_ff @(posedge clock) begin
      if (state_ff == S_NV_WB) begin
         column_mem[k_ff] <= clip_result;
      end
      p_lo_ff <= column_mem[k_ff];
      p_hi_ff <= column_mem[k_ff + 1'b1];
   end

   // ---------------- datapath helpers ----------------
   logic [IDX_W-1:0] n_last_in;
   always_comb begin
      priority if (node_count_ff < COUNT_W'(2)) begin
         n_last_in = IDX_W'(1);
      end else if (node_count_ff > COUNT_W'(MAX_NODES)) begin
         n_last_in = IDX_W'(MAX_NODES - 1);
      end else begin
         n_last_in = IDX_W'(node_count_ff - 1'b1);
      end
   end

   clip_type dl_clip, dr_clip;
   assign dl_clip = clip_sym($signed({t_ff[DATA_W-1], t_ff}) - $signed({x_lo_ff[DATA_W-1], x_lo_ff}));
   assign dr_clip = clip_sym($signed({t_ff[DATA_W-1], t_ff}) - $signed({x_hi_ff[DATA_W-1], x_hi_ff}));

   // One shared multiplier, used for the left and then the right product.
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   assign mul_a = (state_ff == S_NV_MUL_L) ? dl_ff : dr_ff;
   assign mul_b = (state_ff == S_NV_MUL_L) ? pk1_ff : pk_ff;
   assign mul_p = mul_a * mul_b;

   logic signed [PROD_W-1:0] num;
   assign num = prod_l_ff - prod_r_ff;

   logic [DATA_W+1:0] rem_sh;
   logic              q_bit;
   assign rem_sh = {rem_ff[DATA_W:0], quo_ff[PROD_W-1]};
   assign q_bit  = rem_sh >= {1'b0, dmag_ff};

   logic clip_hit;
   always_comb begin
      clip_hit    = 1'b0;
      clip_result = quo_ff[DATA_W-1:0];
      if (qneg_ff) begin
         if (quo_ff > PROD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
            clip_result = Q_MIN;
            clip_hit    = 1'b1;
         end else begin
            clip_result = DATA_W'(-quo_ff);
         end
      end else if (quo_ff > PROD_W'(Q_MAX)) begin
         clip_result = Q_MAX;
         clip_hit    = 1'b1;
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
         k_ff         <= '0;
         m_ff         <= '0;
         n_last_ff    <= '0;
         sat_ff       <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start && req_operation == OP_EVAL) begin
                  t_ff      <= req_query_point;
                  n_last_ff <= n_last_in;
                  a_ff      <= '0;
                  b_ff      <= IDX_W'(1);
                  k_ff      <= '0;
                  m_ff      <= IDX_W'(1);
                  sat_ff    <= 1'b0;
                  state_ff  <= S_DUP_RD;
               end
            end
            S_DUP_RD: begin
               state_ff <= S_DUP_CMP;
            end
            S_DUP_CMP: begin
               if (x_lo_ff == x_hi_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= '0;
                  rsp_dz_ff    <= 1'b1;
                  rsp_sat_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end else if (b_ff == n_last_ff) begin
                  if (a_ff == n_last_ff - 1'b1) begin
                     state_ff <= S_NV_RD;
                  end else begin
                     a_ff     <= a_ff + 1'b1;
                     b_ff     <= a_ff + IDX_W'(2);
                     state_ff <= S_DUP_RD;
                  end
               end else begin
                  b_ff     <= b_ff + 1'b1;
                  state_ff <= S_DUP_RD;
               end
            end
            S_NV_RD: begin
               state_ff <= S_NV_DIFF;
            end
            S_NV_DIFF: begin
               // The first column is the ordinates themselves.
               dl_ff    <= dl_clip.value;
               dr_ff    <= dr_clip.value;
               pk_ff    <= (m_ff == IDX_W'(1)) ? y_lo_ff : p_lo_ff;
               pk1_ff   <= (m_ff == IDX_W'(1)) ? y_hi_ff : p_hi_ff;
               den_ff   <= $signed({x_hi_ff[DATA_W-1], x_hi_ff})
                         - $signed({x_lo_ff[DATA_W-1], x_lo_ff});
               sat_ff   <= sat_ff | dl_clip.clipped | dr_clip.clipped;
               state_ff <= S_NV_MUL_L;
            end
            S_NV_MUL_L: begin
               prod_l_ff <= mul_p;
               state_ff  <= S_NV_MUL_R;
            end
            S_NV_MUL_R: begin
               prod_r_ff <= mul_p;
               state_ff  <= S_NV_NUM;
            end
            S_NV_NUM: begin
               quo_ff     <= num[PROD_W-1] ? PROD_W'(-num) : num;
               dmag_ff    <= den_ff[DATA_W] ? DATA_W'(-den_ff) + {(DATA_W+1){1'b0}}
                                            : den_ff;
               qneg_ff    <= num[PROD_W-1] ^ den_ff[DATA_W];
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               state_ff   <= S_NV_DIV;
            end
            S_NV_DIV: begin
               rem_ff     <= q_bit ? rem_sh - {1'b0, dmag_ff} : rem_sh;
               quo_ff     <= {quo_ff[PROD_W-2:0], q_bit};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
                  state_ff <= S_NV_WB;
               end
            end
            S_NV_WB: begin
               sat_ff <= sat_ff | clip_hit;
               if (k_ff == n_last_ff - m_ff) begin
                  if (m_ff == n_last_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_value_ff <= clip_result;
                     rsp_dz_ff    <= 1'b0;
                     rsp_sat_ff   <= sat_ff | clip_hit;
                     state_ff     <= S_IDLE;
                  end else begin
                     m_ff     <= m_ff + 1'b1;
                     k_ff     <= '0;
                     state_ff <= S_NV_RD;
                  end
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_NV_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_saturated      = rsp_sat_ff;

`ifndef SYNTHESIS
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an evaluation in progress");

   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_value == '0 && !rsp_saturated))
      else $error("divide-by-zero result carries a value or saturation");

   a_wb_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NV_WB) |-> $past(state_ff == S_NV_DIV))
      else $error("write-back without a finished division");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NV_WB) |-> ({1'b0, k_ff} + {1'b0, m_ff} <= {1'b0, n_last_ff}))
      else $error("Neville step beyond the used nodes");

   a_no_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NV_DIV) |-> (dmag_ff != '0))
      else $error("division by zero reached the divider");
`endif

endmodule

`default_nettype wire
